// ===== hdl/link_frame_receive_parser_macros.svh =====
// ----------------------------------------------------------------------------
// link_frame_receive_parser_macros.svh
// Assertion macros used by the frame parser checker.
// ----------------------------------------------------------------------------
`ifndef LINK_FRAME_RECEIVE_PARSER_MACROS_SVH
`define LINK_FRAME_RECEIVE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFRP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfrp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfrp assertion failed");

`endif

// ===== hdl/lfrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrp_pkg
// Types, codes and constants for the link frame receive parser.
// ----------------------------------------------------------------------------
package lfrp_pkg;

    localparam logic [7:0] MAX_PAYLOAD     = 8'd64;
    localparam logic [7:0] ADDR_LAST_INDEX = 8'd3;

    // word kind
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // config register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_TIMEOUT = 1'b1;

    localparam logic [7:0]  START_BYTE_RESET = 8'd239;
    localparam logic [15:0] RX_TIMEOUT_RESET = 16'd1000;

    // status codes
    localparam logic [2:0] ST_CONSUMED = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_GOOD     = 3'd2;
    localparam logic [2:0] ST_CSERR    = 3'd3;
    localparam logic [2:0] ST_LENREJ   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_DEST    = 4'd1,
        PH_SRC     = 4'd2,
        PH_TYPE    = 4'd3,
        PH_SUBTYPE = 4'd4,
        PH_SEQ     = 4'd5,
        PH_LEN     = 4'd6,
        PH_FCS     = 4'd7,
        PH_DATA    = 4'd8
    } phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [7:0]  frame_type;
        logic [7:0]  frame_subtype;
        logic [7:0]  seq_num;
        logic [7:0]  payload_len;
    } result_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] rx_timeout_ticks;
    } cfg_t;

endpackage

// ===== hdl/lfrp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrp_in_reg
// Input register stage: holds one received word for the parser core.
// ----------------------------------------------------------------------------
module lfrp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       in_valid,
    output logic       in_op,
    output logic [7:0] in_byte
);
    import lfrp_pkg::*;

    logic       valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;

    // refill when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_op    = op_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== hdl/lfrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrp_core
// Frame parse state, header registers, checksum and timeout counter.
// ----------------------------------------------------------------------------
module lfrp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic             in_op,
    input  logic [7:0]       in_byte,
    input  lfrp_pkg::cfg_t   cfg,
    output lfrp_pkg::result_t res
);
    import lfrp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  countdown_reg, countdown_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] src_reg, src_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  subtype_reg, subtype_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  fcs_reg, fcs_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] tcount_reg, tcount_next;
    logic        armed_reg, armed_next;

    logic [16:0] tick_cnt;
    logic        tick_expired;
    logic [7:0]  countdown_inc;
    logic        last_payload;
    logic        len_too_long;
    logic [7:0]  xor_with_byte;
    logic [2:0]  verdict;

    assign tick_cnt      = {1'b0, tcount_reg} + 17'd1;
    assign tick_expired  = tick_cnt >= {1'b0, cfg.rx_timeout_ticks};
    assign countdown_inc = countdown_reg + 8'd1;
    assign last_payload  = countdown_inc == len_reg;
    assign len_too_long  = in_byte > MAX_PAYLOAD;
    assign xor_with_byte = xor_reg ^ in_byte;
    // data bytes fold into the sum before the compare
    assign verdict = (((phase_reg == PH_DATA) ? xor_with_byte : xor_reg) == fcs_reg)
                     ? ST_GOOD : ST_CSERR;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            if (in_op == OP_TICK) begin
                if (armed_reg && tick_expired) begin
                    phase_next = PH_HUNT;
                end
            end else begin
                unique case (phase_reg)
                    PH_DEST: begin
                        if (countdown_reg == 8'd0) phase_next = PH_SRC;
                    end
                    PH_SRC: begin
                        if (countdown_reg == 8'd0) phase_next = PH_TYPE;
                    end
                    PH_TYPE:    phase_next = PH_SUBTYPE;
                    PH_SUBTYPE: phase_next = PH_SEQ;
                    PH_SEQ:     phase_next = PH_LEN;
                    PH_LEN:     phase_next = len_too_long ? PH_HUNT : PH_FCS;
                    PH_FCS:     phase_next = (len_reg != 8'd0) ? PH_DATA : PH_HUNT;
                    PH_DATA:    phase_next = last_payload ? PH_HUNT : PH_DATA;
                    default: begin
                        phase_next = (in_byte == cfg.start_byte) ? PH_DEST : PH_HUNT;
                    end
                endcase
            end
        end
    end

    // datapath and result
    always_comb begin
        countdown_next = countdown_reg;
        dest_next      = dest_reg;
        src_next       = src_reg;
        type_next      = type_reg;
        subtype_next   = subtype_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        fcs_next       = fcs_reg;
        xor_next       = xor_reg;
        tcount_next    = tcount_reg;
        armed_next     = armed_reg;
        res            = '0;
        res.status     = ST_CONSUMED;

        if (fire) begin
            if (in_op == OP_TICK) begin
                if (!armed_reg) begin
                    res.status = ST_IGNORED;
                end else if (tick_expired) begin
                    armed_next  = 1'b0;
                    tcount_next = '0;
                    res.status  = ST_TIMEOUT;
                end else begin
                    tcount_next = tick_cnt[15:0];
                end
            end else begin
                unique case (phase_reg)
                    PH_DEST, PH_SRC: begin
                        if (phase_reg == PH_DEST) begin
                            dest_next = {dest_reg[23:0], in_byte};
                        end else begin
                            src_next = {src_reg[23:0], in_byte};
                        end
                        xor_next = xor_with_byte;
                        countdown_next = (countdown_reg == 8'd0) ? ADDR_LAST_INDEX
                                                                 : countdown_reg - 8'd1;
                    end
                    PH_TYPE: begin
                        type_next = in_byte;
                        xor_next  = xor_with_byte;
                    end
                    PH_SUBTYPE: begin
                        subtype_next = in_byte;
                        xor_next     = xor_with_byte;
                    end
                    PH_SEQ: begin
                        seq_next = in_byte;
                        xor_next = xor_with_byte;
                    end
                    PH_LEN: begin
                        len_next = in_byte;
                        xor_next = xor_with_byte;
                        if (len_too_long) begin
                            armed_next  = 1'b0;
                            tcount_next = '0;
                            res.status  = ST_LENREJ;
                        end
                    end
                    PH_FCS: begin
                        fcs_next = in_byte;
                        if (len_reg != 8'd0) begin
                            countdown_next = '0;
                        end else begin
                            // empty payload: verdict on the checksum byte
                            armed_next  = 1'b0;
                            tcount_next = '0;
                            res.status  = ((xor_reg == in_byte) ? ST_GOOD : ST_CSERR);
                        end
                    end
                    PH_DATA: begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = in_byte;
                        res.payload_index = countdown_reg;
                        xor_next          = xor_with_byte;
                        countdown_next    = countdown_inc;
                        if (last_payload) begin
                            armed_next  = 1'b0;
                            tcount_next = '0;
                            res.status  = verdict;
                        end
                    end
                    default: begin
                        if (in_byte == cfg.start_byte) begin
                            xor_next       = in_byte;
                            countdown_next = ADDR_LAST_INDEX;
                            dest_next      = '0;
                            src_next       = '0;
                            armed_next     = 1'b1;
                            tcount_next    = '0;
                        end else begin
                            res.status = ST_IGNORED;
                        end
                    end
                endcase
            end
        end

        // header fields show the registers as left by this word
        res.dest_addr     = dest_next;
        res.source_addr   = src_next;
        res.frame_type    = type_next;
        res.frame_subtype = subtype_next;
        res.seq_num       = seq_next;
        res.payload_len   = len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            countdown_reg <= '0;
            dest_reg      <= '0;
            src_reg       <= '0;
            type_reg      <= '0;
            subtype_reg   <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            fcs_reg       <= '0;
            xor_reg       <= '0;
            tcount_reg    <= '0;
            armed_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            dest_reg      <= dest_next;
            src_reg       <= src_next;
            type_reg      <= type_next;
            subtype_reg   <= subtype_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            fcs_reg       <= fcs_next;
            xor_reg       <= xor_next;
            tcount_reg    <= tcount_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

// ===== hdl/lfrp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrp_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module lfrp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lfrp_pkg::result_t res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output lfrp_pkg::result_t m_res
);
    import lfrp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== hdl/link_frame_receive_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_frame_receive_parser
// Receive-side deframer for a byte-serial link with XOR checksum and timeout.
// ----------------------------------------------------------------------------
// Each input word is either a received byte or one timer tick, and each gives
// exactly one result word. The parser hunts for the start byte, collects a
// 4-byte destination and 4-byte source address (most significant byte first),
// then type, subtype, sequence, length and checksum bytes, and then forwards
// payload bytes one by one with their index. The last payload byte (or the
// checksum byte when the length is zero) carries the verdict: good or
// checksum error, with the header fields alongside. A length above 64 drops
// the frame at the length byte; ticks counted from the start byte abandon an
// unfinished frame once they reach rx_timeout_ticks (0 acts as 1).
// Throughput is one word per clock while the result register is free; a stall
// on m_ready holds it. A word passes the input register, then the result
// register. The input register can take one new word while a finished result
// still waits on m_ready.
// Configuration registers: index 0 start_byte (reset 0xEF), index 1
// rx_timeout_ticks (reset 1000). Write them only while no word is in flight.
// ----------------------------------------------------------------------------
module link_frame_receive_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lfrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lfrp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // received words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [7:0]                          s_rx_byte,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic                                m_payload_valid,
    output logic [7:0]                          m_payload_byte,
    output logic [7:0]                          m_payload_index,
    output logic [31:0]                         m_dest_addr,
    output logic [31:0]                         m_source_addr,
    output logic [7:0]                          m_frame_type,
    output logic [7:0]                          m_frame_subtype,
    output logic [7:0]                          m_seq_num,
    output logic [7:0]                          m_payload_len
);
    import lfrp_pkg::*;

    logic        in_valid;
    logic        in_op;
    logic [7:0]  in_byte;
    logic        out_free;
    logic        fire;
    cfg_t        cfg_reg;
    result_t     core_res;
    result_t     out_res;

    // configuration registers; the narrower one takes the low bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte       <= START_BYTE_RESET;
            cfg_reg.rx_timeout_ticks <= RX_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_BYTE: cfg_reg.start_byte       <= cfg_wdata[7:0];
                CFG_RX_TIMEOUT: cfg_reg.rx_timeout_ticks <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // a word is processed when it sits in the input register and the
    // result register can take its result
    assign fire = in_valid && out_free;

    lfrp_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_rx_byte   (s_rx_byte),
        .take        (out_free),
        .in_valid    (in_valid),
        .in_op       (in_op),
        .in_byte     (in_byte)
    );

    lfrp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_op   (in_op),
        .in_byte (in_byte),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

    lfrp_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .res     (core_res),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (out_res)
    );

    assign m_status        = out_res.status;
    assign m_payload_valid = out_res.payload_valid;
    assign m_payload_byte  = out_res.payload_byte;
    assign m_payload_index = out_res.payload_index;
    assign m_dest_addr     = out_res.dest_addr;
    assign m_source_addr   = out_res.source_addr;
    assign m_frame_type    = out_res.frame_type;
    assign m_frame_subtype = out_res.frame_subtype;
    assign m_seq_num       = out_res.seq_num;
    assign m_payload_len   = out_res.payload_len;

endmodule

// ===== hdl/lfrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
`include "link_frame_receive_parser_macros.svh"

module lfrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic        m_payload_valid,
    input logic [7:0]  m_payload_byte,
    input logic [7:0]  m_payload_index,
    input logic [7:0]  m_payload_len
);
    import lfrp_pkg::*;

    // payload words are plain data or carry the frame verdict
    `LFRP_ASSERT_NOW(a_payload_status, aclk, aresetn, m_valid && m_payload_valid, m_status == ST_CONSUMED || m_status == ST_GOOD || m_status == ST_CSERR)

    // payload index lies inside the announced length
    `LFRP_ASSERT_NOW(a_payload_index, aclk, aresetn, m_valid && m_payload_valid, m_payload_index < m_payload_len)

    // non-payload words carry zero payload fields
    `LFRP_ASSERT_NOW(a_payload_idle, aclk, aresetn, m_valid && !m_payload_valid, m_payload_byte == 8'd0 && m_payload_index == 8'd0)

    // a stalled result holds
    `LFRP_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_payload_byte))

endmodule

bind link_frame_receive_parser lfrp_checker u_lfrp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_payload_valid (m_payload_valid),
    .m_payload_byte  (m_payload_byte),
    .m_payload_index (m_payload_index),
    .m_payload_len   (m_payload_len)
);
